/* hw/rtl/rofsdt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rofsdt_pkg;

    localparam int unsigned MAX_PAGES_DEF = 16;
    localparam int unsigned MAX_ROWS_DEF  = 256;

    // page * height + row before truncation to the store address
    localparam int unsigned BASE_W = 14;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_TAKE = 2'd2;

    localparam logic [2:0] ROP_COPY     = 3'd0;
    localparam logic [2:0] ROP_INV_COPY = 3'd1;
    localparam logic [2:0] ROP_INVERT   = 3'd2;
    localparam logic [2:0] ROP_XOR      = 3'd3;
    localparam logic [2:0] ROP_CLEAR    = 3'd4;
    localparam logic [2:0] ROP_SET      = 3'd5;

    localparam logic [1:0] CFG_RASTER_OP = 2'd0;
    localparam logic [1:0] CFG_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_HEIGHT    = 2'd2;

    localparam logic [2:0] RESET_RASTER_OP = 3'd0;
    localparam logic [7:0] RESET_WIDTH     = 8'd128;
    localparam logic [8:0] RESET_HEIGHT    = 9'd256;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] x_first;
        logic [7:0] y_first;
        logic [7:0] x_last;
        logic [7:0] y_last;
        logic       color;
    } in_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] range_low;
        logic [7:0] range_high;
        logic       range_empty;
        logic       rejected;
    } out_word_t;

    // effective raster op and display geometry
    typedef struct packed {
        logic [2:0] rop;
        logic [5:0] pages;
        logic [8:0] height;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_DRAW,
        ST_READ,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIRTY_NONE,
        DIRTY_MERGE,
        DIRTY_TAKE
    } dirty_cmd_t;

    typedef struct packed {
        dirty_cmd_t cmd;
        logic [4:0] page;
        logic [7:0] lo;
        logic [7:0] hi;
    } dirty_req_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] lo;
        logic [7:0] hi;
    } dirty_rsp_t;

    function automatic logic [7:0] span_mask(input logic [2:0] sb, input logic [2:0] eb);
        logic [7:0] lo_part;
        logic [7:0] hi_part;
        lo_part = BYTE_ONES >> sb;
        hi_part = BYTE_ONES << (3'd7 - eb);
        return lo_part & hi_part;
    endfunction

    function automatic logic [7:0] apply_rop(input logic [2:0] rop, input logic [7:0] dst,
                                             input logic [7:0] src_all,
                                             input logic [7:0] mask);
        logic [7:0] keep;
        logic [7:0] src;
        logic [7:0] res;
        keep = dst & ~mask;
        src  = src_all & mask;
        case (rop)
            ROP_COPY:     res = keep | (src & mask);
            ROP_INV_COPY: res = keep | (~src & mask);
            ROP_INVERT:   res = keep | (~dst & mask);
            ROP_XOR:      res = keep | ((dst ^ src) & mask);
            ROP_CLEAR:    res = keep;
            ROP_SET:      res = dst | mask;
            default:      res = dst;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rofsdt_frame_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module rofsdt_frame_mem #(
    parameter int unsigned DEPTH  = rofsdt_pkg::MAX_PAGES_DEF * rofsdt_pkg::MAX_ROWS_DEF,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [7:0]        rdata
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/rofsdt_dirty_tbl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rofsdt_dirty_tbl #(
    parameter int unsigned MAX_PAGES = rofsdt_pkg::MAX_PAGES_DEF,
    localparam int unsigned PAGE_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire rofsdt_pkg::dirty_req_t req,
    output rofsdt_pkg::dirty_rsp_t      rsp
);

    logic [MAX_PAGES-1:0] valid_reg;
    logic [7:0]           lo_reg [MAX_PAGES];
    logic [7:0]           hi_reg [MAX_PAGES];
    logic [PAGE_W-1:0]    idx;

    assign idx = req.page[PAGE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            case (req.cmd)
                rofsdt_pkg::DIRTY_MERGE: valid_reg[idx] <= 1'b1;
                rofsdt_pkg::DIRTY_TAKE:  valid_reg[idx] <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (req.cmd == rofsdt_pkg::DIRTY_MERGE) begin
            if (!valid_reg[idx] || (req.lo < lo_reg[idx])) begin
                lo_reg[idx] <= req.lo;
            end
            if (!valid_reg[idx] || (req.hi > hi_reg[idx])) begin
                hi_reg[idx] <= req.hi;
            end
        end
    end

    assign rsp.valid = valid_reg[idx];
    assign rsp.lo    = lo_reg[idx];
    assign rsp.hi    = hi_reg[idx];

endmodule

`default_nettype wire

/* hw/rtl/rofsdt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rofsdt_ctrl #(
    parameter int unsigned MAX_PAGES  = rofsdt_pkg::MAX_PAGES_DEF,
    parameter int unsigned MAX_ROWS   = rofsdt_pkg::MAX_ROWS_DEF,
    localparam int unsigned STORE_DEPTH = MAX_PAGES * MAX_ROWS,
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire rofsdt_pkg::cfg_t       cfg,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire rofsdt_pkg::in_word_t   s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output rofsdt_pkg::out_word_t       m_data,
    output logic                        mem_we,
    output logic [ADDR_W-1:0]           mem_waddr,
    output logic [7:0]                  mem_wdata,
    output logic                        mem_re,
    output logic [ADDR_W-1:0]           mem_raddr,
    input  wire logic [7:0]             mem_rdata,
    output rofsdt_pkg::dirty_req_t      dirty_req,
    input  wire rofsdt_pkg::dirty_rsp_t dirty_rsp
);

    rofsdt_pkg::state_t    state_reg, state_next;
    logic [ADDR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    rofsdt_pkg::in_word_t  item_reg, item_next;
    logic [4:0]            p_cur_reg, p_cur_next;
    logic [4:0]            p_first_reg, p_first_next;
    logic [4:0]            p_last_reg, p_last_next;
    logic [2:0]            sb_reg, sb_next;
    logic [2:0]            eb_reg, eb_next;
    logic [7:0]            y_cur_reg, y_cur_next;
    logic [7:0]            y_lo_reg, y_lo_next;
    logic [7:0]            y_hi_reg, y_hi_next;
    logic [rofsdt_pkg::BASE_W-1:0] base_reg, base_next;
    logic                  wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0]     wb_addr_reg, wb_addr_next;
    logic [7:0]            wb_mask_reg, wb_mask_next;
    rofsdt_pkg::out_word_t res_reg, res_next;
    logic                  rd_sel_reg, rd_sel_next;
    logic                  m_valid_reg, m_valid_next;
    rofsdt_pkg::out_word_t m_data_reg, m_data_next;

    logic [8:0] w9, w_m1, h_m1;
    logic [7:0] xa, xb, ya, yb, xb_c, yb_c;
    logic [4:0] rd_page, page_sel;
    logic       draw_rej, read_rej, take_rej;
    logic       last_row, last_page, out_free;
    logic [rofsdt_pkg::BASE_W-1:0] addr_sum;
    logic [7:0] src_all;

    assign w9   = {cfg.pages, 3'b000};
    assign w_m1 = w9 - 9'd1;
    assign h_m1 = cfg.height - 9'd1;

    assign xa   = (item_reg.x_first <= item_reg.x_last) ? item_reg.x_first : item_reg.x_last;
    assign xb   = (item_reg.x_first <= item_reg.x_last) ? item_reg.x_last : item_reg.x_first;
    assign ya   = (item_reg.y_first <= item_reg.y_last) ? item_reg.y_first : item_reg.y_last;
    assign yb   = (item_reg.y_first <= item_reg.y_last) ? item_reg.y_last : item_reg.y_first;
    assign xb_c = ({1'b0, xb} >= w9) ? w_m1[7:0] : xb;
    assign yb_c = ({1'b0, yb} >= cfg.height) ? h_m1[7:0] : yb;

    assign rd_page  = item_reg.x_first[7:3];
    assign draw_rej = ({1'b0, item_reg.x_first} >= w9) ||
                      ({1'b0, item_reg.y_first} >= cfg.height);
    assign read_rej = ({1'b0, rd_page} >= cfg.pages) ||
                      ({1'b0, item_reg.y_first} >= cfg.height);
    assign take_rej = ({1'b0, rd_page} >= cfg.pages);
    assign page_sel = (item_reg.op == rofsdt_pkg::OP_DRAW) ? xa[7:3] : rd_page;

    assign last_row  = (y_cur_reg == y_hi_reg);
    assign last_page = (p_cur_reg == p_last_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign addr_sum  = base_reg + {{(rofsdt_pkg::BASE_W-8){1'b0}}, y_cur_reg};
    assign src_all   = item_reg.color ? rofsdt_pkg::BYTE_ONES : 8'h00;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rofsdt_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    state_next = rofsdt_pkg::ST_IDLE;
                end
            end
            rofsdt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rofsdt_pkg::ST_DECODE;
                end
            end
            rofsdt_pkg::ST_DECODE: begin
                case (item_reg.op)
                    rofsdt_pkg::OP_DRAW: begin
                        state_next = draw_rej ? rofsdt_pkg::ST_DONE : rofsdt_pkg::ST_DRAW;
                    end
                    rofsdt_pkg::OP_READ: begin
                        state_next = read_rej ? rofsdt_pkg::ST_DONE : rofsdt_pkg::ST_READ;
                    end
                    default: state_next = rofsdt_pkg::ST_DONE;
                endcase
            end
            rofsdt_pkg::ST_DRAW: begin
                if (last_row && last_page) begin
                    state_next = rofsdt_pkg::ST_DONE;
                end
            end
            rofsdt_pkg::ST_READ: state_next = rofsdt_pkg::ST_DONE;
            rofsdt_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = rofsdt_pkg::ST_IDLE;
                end
            end
            default: state_next = rofsdt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        item_next     = item_reg;
        p_cur_next    = p_cur_reg;
        p_first_next  = p_first_reg;
        p_last_next   = p_last_reg;
        sb_next       = sb_reg;
        eb_next       = eb_reg;
        y_cur_next    = y_cur_reg;
        y_lo_next     = y_lo_reg;
        y_hi_next     = y_hi_reg;
        base_next     = base_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = addr_sum[ADDR_W-1:0];
        wb_mask_next  = rofsdt_pkg::span_mask((p_cur_reg == p_first_reg) ? sb_reg : 3'd0,
                                              last_page ? eb_reg : 3'd7);
        res_next      = res_reg;
        rd_sel_next   = rd_sel_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        s_ready       = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = addr_sum[ADDR_W-1:0];
        mem_we        = wb_valid_reg;
        mem_waddr     = wb_addr_reg;
        mem_wdata     = rofsdt_pkg::apply_rop(cfg.rop, mem_rdata, src_all, wb_mask_reg);
        dirty_req     = '{cmd: rofsdt_pkg::DIRTY_NONE, page: p_cur_reg,
                          lo: y_lo_reg, hi: y_hi_reg};

        case (state_reg)
            rofsdt_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = 8'h00;
            end
            rofsdt_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                item_next = s_data;
            end
            rofsdt_pkg::ST_DECODE: begin
                res_next     = '0;
                rd_sel_next  = 1'b0;
                p_cur_next   = xa[7:3];
                p_first_next = xa[7:3];
                p_last_next  = xb_c[7:3];
                sb_next      = xa[2:0];
                eb_next      = xb_c[2:0];
                y_lo_next    = ya;
                y_hi_next    = yb_c;
                y_cur_next   = (item_reg.op == rofsdt_pkg::OP_DRAW) ? ya : item_reg.y_first;
                base_next    = {{(rofsdt_pkg::BASE_W-5){1'b0}}, page_sel} *
                               {{(rofsdt_pkg::BASE_W-9){1'b0}}, cfg.height};
                case (item_reg.op)
                    rofsdt_pkg::OP_DRAW: res_next.rejected = draw_rej;
                    rofsdt_pkg::OP_READ: begin
                        res_next.rejected = read_rej;
                        rd_sel_next       = !read_rej;
                    end
                    rofsdt_pkg::OP_TAKE: begin
                        if (take_rej) begin
                            res_next.rejected    = 1'b1;
                            res_next.range_empty = 1'b1;
                        end else begin
                            dirty_req.cmd        = rofsdt_pkg::DIRTY_TAKE;
                            dirty_req.page       = rd_page;
                            res_next.range_empty = !dirty_rsp.valid;
                            res_next.range_low   = dirty_rsp.valid ? dirty_rsp.lo : 8'h00;
                            res_next.range_high  = dirty_rsp.valid ? dirty_rsp.hi : 8'h00;
                        end
                    end
                    default: ;
                endcase
            end
            rofsdt_pkg::ST_DRAW: begin
                mem_re        = 1'b1;
                wb_valid_next = 1'b1;
                if (last_row) begin
                    dirty_req.cmd = rofsdt_pkg::DIRTY_MERGE;
                    p_cur_next    = p_cur_reg + 5'd1;
                    base_next     = base_reg + {{(rofsdt_pkg::BASE_W-9){1'b0}}, cfg.height};
                    y_cur_next    = y_lo_reg;
                end else begin
                    y_cur_next = y_cur_reg + 8'd1;
                end
            end
            rofsdt_pkg::ST_READ: begin
                mem_re = 1'b1;
            end
            rofsdt_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    if (rd_sel_reg) begin
                        m_data_next.read_data = mem_rdata;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rofsdt_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            wb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            wb_valid_reg <= wb_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        p_cur_reg   <= p_cur_next;
        p_first_reg <= p_first_next;
        p_last_reg  <= p_last_next;
        sb_reg      <= sb_next;
        eb_reg      <= eb_next;
        y_cur_reg   <= y_cur_next;
        y_lo_reg    <= y_lo_next;
        y_hi_reg    <= y_hi_next;
        base_reg    <= base_next;
        wb_addr_reg <= wb_addr_next;
        wb_mask_reg <= wb_mask_next;
        res_reg     <= res_next;
        rd_sel_reg  <= rd_sel_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // write-back must never hit the byte being read in the same cycle
    a_rmw_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wb_valid_reg && mem_re) |-> (wb_addr_reg != mem_raddr))
        else $error("read-modify-write overlap on one frame byte");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rofsdt_pkg::ST_CLEAR) |-> !s_ready)
        else $error("input taken during store clear");

    a_wb_follows_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_valid_reg |-> ($past(state_reg) == rofsdt_pkg::ST_DRAW))
        else $error("write-back without a draw read");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == rofsdt_pkg::ST_DONE))
        else $error("result word raised outside done state");

endmodule

`default_nettype wire

/* hw/rtl/raster_op_frame_store_dirty_track_unit.sv */
// Flow: decode, then a draw state (P pages by R rows after clipping, one frame byte
//   read-modify-write per cycle) or a read state for a byte read, then done, which
//   loads the result word after any wait for m_ready; a take, unused op or rejected word
//   goes straight to done. Throughput: one word at a time; next input taken in the
//   cycle after the result loads. Config writes taken always. Reset: synchronous active
//   low; MAX_PAGES*MAX_ROWS store bytes (4096 by default) are zeroed with s_ready low.
`timescale 1ns / 1ps
`default_nettype none

module raster_op_frame_store_dirty_track_unit #(
    parameter int unsigned MAX_PAGES = rofsdt_pkg::MAX_PAGES_DEF,
    parameter int unsigned MAX_ROWS  = rofsdt_pkg::MAX_ROWS_DEF,
    localparam int unsigned STORE_DEPTH = MAX_PAGES * MAX_ROWS,
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [8:0]            cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire rofsdt_pkg::in_word_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output rofsdt_pkg::out_word_t      m_data
);

    logic [2:0] rop_reg;
    logic [7:0] width_reg;
    logic [8:0] height_reg;
    logic [5:0] pages_raw;
    rofsdt_pkg::cfg_t cfg;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, mem_rdata;
    rofsdt_pkg::dirty_req_t dirty_req;
    rofsdt_pkg::dirty_rsp_t dirty_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rop_reg    <= rofsdt_pkg::RESET_RASTER_OP;
            width_reg  <= rofsdt_pkg::RESET_WIDTH;
            height_reg <= rofsdt_pkg::RESET_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rofsdt_pkg::CFG_RASTER_OP: rop_reg    <= cfg_data[2:0];
                rofsdt_pkg::CFG_WIDTH:     width_reg  <= cfg_data[7:0];
                rofsdt_pkg::CFG_HEIGHT:    height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pages_raw  = {1'b0, width_reg[7:3]};
    assign cfg.rop    = rop_reg;
    assign cfg.pages  = (pages_raw > 6'(MAX_PAGES)) ? 6'(MAX_PAGES) : pages_raw;
    assign cfg.height = (height_reg > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : height_reg;

    rofsdt_ctrl #(
        .MAX_PAGES (MAX_PAGES),
        .MAX_ROWS  (MAX_ROWS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .dirty_req (dirty_req),
        .dirty_rsp (dirty_rsp)
    );

    rofsdt_frame_mem #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_frame_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rofsdt_dirty_tbl #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dirty_tbl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dirty_req),
        .rsp     (dirty_rsp)
    );

endmodule

`default_nettype wire
